// ===== hw/rtl/hrp_pkg.sv =====
`default_nettype none
package hrp_pkg;

   // Width of the length accumulator; the rsp_length port carries its low 32 bits.
   localparam int LenBits = 32;
   // Room for acc * 16 + 15 without wrapping.
   localparam int AccW = LenBits + 5;

   localparam logic [1:0] PhStatus  = 2'd0;
   localparam logic [1:0] PhHeaders = 2'd1;
   localparam logic [1:0] PhBody    = 2'd2;
   localparam logic [1:0] PhBroken  = 2'd3;

   // Status line scan steps
   localparam logic [3:0] SLit     = 4'd0;
   localparam logic [3:0] SMinWs   = 4'd1;
   localparam logic [3:0] SMinSign = 4'd2;
   localparam logic [3:0] SMinDig  = 4'd3;
   localparam logic [3:0] SStWs    = 4'd4;
   localparam logic [3:0] SStSign  = 4'd5;
   localparam logic [3:0] SStDig   = 4'd6;
   localparam logic [3:0] SDone    = 4'd7;
   localparam logic [3:0] SFail    = 4'd8;

   // Header line scan steps
   localparam logic [3:0] HLit   = 4'd0;
   localparam logic [3:0] HWs    = 4'd1;
   localparam logic [3:0] HSign  = 4'd2;
   localparam logic [3:0] HZero  = 4'd3;
   localparam logic [3:0] HZeroX = 4'd4;
   localparam logic [3:0] HDig   = 4'd5;
   localparam logic [3:0] HEnd   = 4'd6;
   localparam logic [3:0] HSkip  = 4'd7;

   localparam logic [1:0] BaseNone = 2'd0;
   localparam logic [1:0] BaseOct  = 2'd1;
   localparam logic [1:0] BaseDec  = 2'd2;
   localparam logic [1:0] BaseHex  = 2'd3;

   localparam logic [AccW-1:0] StatusCap = AccW'(32768);
   localparam logic [4:0]      PosMax    = 5'd31;

   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChLf = 8'h0A;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_value;
   } item_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic               cr;
      logic [4:0]         pos;
      logic [3:0]         step;
      logic [LenBits-1:0] acc;
      logic               neg;
      logic [1:0]         base;
      logic               ovf;
      logic [15:0]        status;
      logic [LenBits-1:0] len;
      logic               seen;
   } scan_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/hrp_in_reg.sv =====
`default_nettype none
module hrp_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic              take,
   output logic                   item_valid,
   output hrp_pkg::item_type      item
);
   import hrp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd        <= req_cmd;
         item_ff.byte_value <= req_byte_value;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/hrp_core.sv =====
`default_nettype none
module hrp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire hrp_pkg::item_type  item,
   output logic                    take,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_phase,
   output logic signed [15:0]      rsp_status,
   output logic [31:0]             rsp_length,
   output logic                    rsp_has_length,
   output logic                    rsp_headers_pending
);
   import hrp_pkg::*;

   function automatic logic is_ws(logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_dec(logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic [5:0] digit_of(logic [7:0] c);
      logic [5:0] d;
      d = 6'd63;
      if (c inside {["0":"9"]}) d = 6'(c - "0");
      else if (c inside {["a":"z"]}) d = 6'(c - "a" + 8'd10);
      else if (c inside {["A":"Z"]}) d = 6'(c - "A" + 8'd10);
      return d;
   endfunction

   function automatic logic [7:0] status_lit(logic [2:0] i);
      logic [7:0] ch;
      case (i)
         3'd0: ch = "H";
         3'd1: ch = "T";
         3'd2: ch = "T";
         3'd3: ch = "P";
         3'd4: ch = "/";
         3'd5: ch = "1";
         3'd6: ch = ".";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] length_lit(logic [3:0] i);
      logic [7:0] ch;
      case (i)
         4'd0:  ch = "C";
         4'd1:  ch = "o";
         4'd2:  ch = "n";
         4'd3:  ch = "t";
         4'd4:  ch = "e";
         4'd5:  ch = "n";
         4'd6:  ch = "t";
         4'd7:  ch = "-";
         4'd8:  ch = "L";
         4'd9:  ch = "e";
         4'd10: ch = "n";
         4'd11: ch = "g";
         4'd12: ch = "t";
         4'd13: ch = "h";
         4'd14: ch = ":";
         4'd15: ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // acc * 10 + d by shifts, capped at 32768
   function automatic scan_state_type status_add(scan_state_type s, logic [7:0] c);
      scan_state_type   n;
      logic [AccW-1:0]  a, w;
      n = s;
      a = AccW'(s.acc);
      w = (a << 3) + (a << 1) + AccW'(c - "0");
      if (w > StatusCap) n.acc = LenBits'(StatusCap);
      else n.acc = w[LenBits-1:0];
      return n;
   endfunction

   // acc * base + d; result above the maximum sets the overflow flag
   function automatic scan_state_type length_add(scan_state_type s, logic [5:0] d);
      scan_state_type   n;
      logic [AccW-1:0]  a, w;
      n = s;
      a = AccW'(s.acc);
      case (s.base)
         BaseOct: w = a << 3;
         BaseHex: w = a << 4;
         default: w = (a << 3) + (a << 1);
      endcase
      w = w + AccW'(d);
      if (!s.ovf) begin
         if (w[AccW-1:LenBits] != '0) begin
            n.ovf = 1'b1;
            n.acc = '1;
         end else begin
            n.acc = w[LenBits-1:0];
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] base_limit(logic [1:0] b);
      logic [5:0] r;
      case (b)
         BaseOct: r = 6'd8;
         BaseHex: r = 6'd16;
         default: r = 6'd10;
      endcase
      return r;
   endfunction

   function automatic scan_state_type status_char(scan_state_type s, logic [7:0] c);
      scan_state_type n;
      n = s;
      if (c == 8'h00) begin
         n.step = (s.step == SStDig || s.step == SDone) ? SDone : SFail;
      end else begin
         case (s.step)
            SLit: begin
               if (s.pos < 5'd7 && c == status_lit(s.pos[2:0]))
                  n.step = (s.pos == 5'd6) ? SMinWs : SLit;
               else
                  n.step = SFail;
            end
            SMinWs: begin
               if (!is_ws(c)) begin
                  if (c == "+" || c == "-") n.step = SMinSign;
                  else if (is_dec(c)) n.step = SMinDig;
                  else n.step = SFail;
               end
            end
            SMinSign: n.step = is_dec(c) ? SMinDig : SFail;
            SMinDig, SStWs: begin
               if (!(s.step == SMinDig && is_dec(c))) begin
                  n.step = SStWs;
                  if (!is_ws(c)) begin
                     if (c == "+" || c == "-") begin
                        n.neg  = (c == "-");
                        n.step = SStSign;
                     end else if (is_dec(c)) begin
                        n.acc  = '0;
                        n      = status_add(n, c);
                        n.step = SStDig;
                     end else begin
                        n.step = SFail;
                     end
                  end
               end
            end
            SStSign: begin
               if (is_dec(c)) begin
                  n.acc  = '0;
                  n      = status_add(n, c);
                  n.step = SStDig;
               end else begin
                  n.step = SFail;
               end
            end
            SStDig: begin
               if (is_dec(c)) n = status_add(n, c);
               else n.step = SDone;
            end
            default: ;
         endcase
      end
      return n;
   endfunction

   function automatic scan_state_type header_char(scan_state_type s, logic [7:0] c);
      scan_state_type n;
      logic [5:0]     d;
      n = s;
      d = digit_of(c);
      case (s.step)
         HLit: begin
            if (c == length_lit(s.pos[3:0]) && s.pos < 5'd16)
               n.step = (s.pos == 5'd15) ? HWs : HLit;
            else
               n.step = HSkip;
         end
         HWs, HSign: begin
            if (s.step == HWs && is_ws(c)) begin
               n.step = HWs;
            end else if (s.step == HWs && (c == "+" || c == "-")) begin
               n.neg  = (c == "-");
               n.step = HSign;
            end else if (c == "0") begin
               n.step = HZero;
            end else if (is_dec(c)) begin
               n.base = BaseDec;
               n.acc  = '0;
               n      = length_add(n, d);
               n.step = HDig;
            end else begin
               n.acc  = '0;
               n.neg  = 1'b0;
               n.step = HEnd;
            end
         end
         HZero: begin
            if (c == "x" || c == "X") begin
               n.step = HZeroX;
            end else if (c inside {["0":"7"]}) begin
               n.base = BaseOct;
               n      = length_add(n, d);
               n.step = HDig;
            end else begin
               n.step = HEnd;
            end
         end
         HZeroX: begin
            if (d < 6'd16) begin
               n.base = BaseHex;
               n      = length_add(n, d);
               n.step = HDig;
            end else begin
               n.step = HEnd;
            end
         end
         HDig: begin
            if (d < base_limit(s.base)) n = length_add(n, d);
            else n.step = HEnd;
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic scan_state_type content_byte(scan_state_type s, logic [7:0] c);
      scan_state_type n;
      if (s.phase == PhStatus) n = status_char(s, c);
      else n = header_char(s, c);
      if (s.pos < PosMax) n.pos = s.pos + 5'd1;
      return n;
   endfunction

   function automatic scan_state_type line_end(scan_state_type s);
      scan_state_type     n;
      logic [15:0]        m;
      logic [LenBits-1:0] v;
      n = s;
      m = s.acc[15:0];
      v = '0;
      if (s.phase == PhStatus) begin
         if (s.step == SStDig || s.step == SDone) begin
            if (s.neg) n.status = 16'd0 - m;
            else n.status = (m > 16'd32767) ? 16'd32767 : m;
            n.phase = PhHeaders;
         end else begin
            n.phase = PhBroken;
         end
      end else if (s.pos == 5'd0) begin
         n.phase = PhBody;
      end else if (s.step >= HWs && s.step <= HEnd) begin
         if (s.step == HDig || s.step == HEnd) v = s.acc;
         if (s.ovf) v = '1;
         else if (s.neg) v = '0 - v;
         n.len  = v;
         n.seen = 1'b1;
      end
      n.cr   = 1'b0;
      n.pos  = '0;
      n.step = '0;
      n.acc  = '0;
      n.neg  = 1'b0;
      n.base = BaseNone;
      n.ovf  = 1'b0;
      return n;
   endfunction

   scan_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     phase_ff;
   logic [15:0]    status_ff;
   logic [31:0]    length_ff;
   logic           seen_ff;
   logic [63:0]    len_wide;

   assign take = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      if (item.cmd) begin
         state_in.phase = PhBroken;
      end else if (state_ff.phase == PhStatus || state_ff.phase == PhHeaders) begin
         if (state_ff.cr) begin
            if (item.byte_value == ChLf) begin
               state_in = line_end(state_ff);
            end else begin
               // held CR was plain content
               state_in.cr = 1'b0;
               state_in    = content_byte(state_in, ChCr);
               if (item.byte_value == ChCr) state_in.cr = 1'b1;
               else state_in = content_byte(state_in, item.byte_value);
            end
         end else if (item.byte_value == ChCr) begin
            state_in.cr = 1'b1;
         end else begin
            state_in = content_byte(state_ff, item.byte_value);
         end
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
   assign len_wide     = 64'(state_in.len);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         phase_ff  <= state_in.phase;
         status_ff <= state_in.status;
         length_ff <= len_wide[31:0];
         seen_ff   <= state_in.seen;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = phase_ff;
   assign rsp_status          = status_ff;
   assign rsp_length          = length_ff;
   assign rsp_has_length      = seen_ff;
   assign rsp_headers_pending = (phase_ff == PhStatus || phase_ff == PhHeaders);
endmodule
`default_nettype wire

// ===== hw/rtl/http_response_header_parser.sv =====
// Path: an accepted item enters the input register, and its result is loaded into the
// result register when the core takes the item.
// Throughput: 1 item per cycle unless the output stalls; each byte is decoded by one
// combinational pass over the line scanner state, including a CR held from the previous item.
// A stalled result keeps its register while one more item waits in the input register.
// Reset (synchronous, active high) returns to the status line phase with all scanner state zero.
`default_nettype none
module http_response_header_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_cmd,
   input  wire logic [7:0]         req_byte_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_phase,
   output logic signed [15:0]      rsp_status,
   output logic [31:0]             rsp_length,
   output logic                    rsp_has_length,
   output logic                    rsp_headers_pending
);
   import hrp_pkg::*;

   logic     take;
   logic     item_valid;
   item_type item;

   hrp_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .take           (take),
      .item_valid     (item_valid),
      .item           (item)
   );

   hrp_core u_core (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (item),
      .take                (take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phase           (rsp_phase),
      .rsp_status          (rsp_status),
      .rsp_length          (rsp_length),
      .rsp_has_length      (rsp_has_length),
      .rsp_headers_pending (rsp_headers_pending)
   );

   // both stages full and output blocked: no room for another item
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (item_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("item accepted with both stages full");

   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_headers_pending == (rsp_phase == PhStatus || rsp_phase == PhHeaders)))
      else $error("headers_pending disagrees with phase");

   // no status or length is reported before the status line is accepted
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == PhStatus) |-> (rsp_status == 16'sd0 && !rsp_has_length))
      else $error("values set while still in status line phase");

   a_take_drains: assert property (@(posedge clock) disable iff (reset)
      (take && !(req_valid && !req_stall)) |=> !item_valid)
      else $error("input stage not drained after take");
endmodule
`default_nettype wire

// ===== bench/http_response_header_parser_tb.sv =====
`default_nettype none
module http_response_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hrp_pkg::*;

   localparam int          ItemTarget = 1920;
   localparam int          CycleLimit = 400000;
   localparam int          QuietFirst = 600;
   localparam int          QuietLast  = 900;
   localparam logic [63:0] LenMax     = 64'((65'd1 << LenBits) - 65'd1);

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] status;
      logic [31:0] body_len;
      logic        has_length;
      logic        headers_pending;
   } parse_view_type;

   class parse_scoreboard;
      parse_view_type expected_views[$];
      int          errors;
      string       status_prefix;
      string       length_prefix;

      logic [1:0]  phase;
      logic        cr;
      logic [4:0]  pos;
      logic [3:0]  step;
      logic [63:0] acc;
      logic        neg;
      logic [1:0]  base;
      logic        ovf;
      logic [15:0] status;
      logic [63:0] len;
      logic        seen;

      function new();
         status_prefix = "HTTP/1.";
         length_prefix = "Content-Length: ";
         errors = 0;
         phase = PhStatus;
         status = '0;
         len = '0;
         seen = 1'b0;
         clear_line();
      endfunction

      function void clear_line();
         cr = 1'b0;
         pos = '0;
         step = SLit;
         acc = '0;
         neg = 1'b0;
         base = BaseNone;
         ovf = 1'b0;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit is_decimal(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic [6:0] digit_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return 7'(c - "0");
         if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd10);
         if (c >= "A" && c <= "Z") return 7'(c - "A" + 8'd10);
         return 7'd99;
      endfunction

      function logic [63:0] radix();
         return base == BaseOct ? 64'd8 : (base == BaseHex ? 64'd16 : 64'd10);
      endfunction

      function void add_status_digit(logic [7:0] c);
         acc = acc * 64'd10 + 64'(c - "0");
         if (acc > 64'd32768) acc = 64'd32768;
      endfunction

      // Once saturated the length ignores further digits.
      function void add_length_digit(logic [63:0] d);
         logic [63:0] b;
         b = radix();
         if (!ovf) begin
            if (acc > (LenMax - d) / b) begin
               ovf = 1'b1;
               acc = LenMax;
            end else begin
               acc = acc * b + d;
            end
         end
      endfunction

      // sscanf-style match of "HTTP/1.%d %d"
      function void status_char(logic [7:0] c);
         if (c == 8'h00) begin
            step = (step == SStDig || step == SDone) ? SDone : SFail;
         end else begin
            case (step)
               SLit: begin
                  if (pos < 5'd7 && c == status_prefix[pos]) step = (pos == 5'd6) ? SMinWs : SLit;
                  else step = SFail;
               end
               SMinWs: begin
                  if (is_space(c)) ;
                  else if (c == "+" || c == "-") step = SMinSign;
                  else if (is_decimal(c)) step = SMinDig;
                  else step = SFail;
               end
               SMinSign: step = is_decimal(c) ? SMinDig : SFail;
               SMinDig, SStWs: begin
                  if (step == SMinDig && is_decimal(c)) ;
                  else begin
                     step = SStWs;
                     if (is_space(c)) ;
                     else if (c == "+" || c == "-") begin
                        neg = (c == "-");
                        step = SStSign;
                     end else if (is_decimal(c)) begin
                        acc = '0;
                        add_status_digit(c);
                        step = SStDig;
                     end else begin
                        step = SFail;
                     end
                  end
               end
               SStSign: begin
                  if (is_decimal(c)) begin
                     acc = '0;
                     add_status_digit(c);
                     step = SStDig;
                  end else begin
                     step = SFail;
                  end
               end
               SStDig: begin
                  if (is_decimal(c)) add_status_digit(c);
                  else step = SDone;
               end
               default: ;
            endcase
         end
      endfunction

      // strtoul base 0 on a line that starts with the length prefix
      function void header_char(logic [7:0] c);
         logic [6:0] d;
         d = digit_value(c);
         case (step)
            HLit: begin
               if (pos < 5'd16 && c == length_prefix[pos]) step = (pos == 5'd15) ? HWs : HLit;
               else step = HSkip;
            end
            HWs, HSign: begin
               if (step == HWs && is_space(c)) ;
               else if (step == HWs && (c == "+" || c == "-")) begin
                  neg = (c == "-");
                  step = HSign;
               end else if (c == "0") begin
                  step = HZero;
               end else if (is_decimal(c)) begin
                  base = BaseDec;
                  acc = '0;
                  add_length_digit(64'(d));
                  step = HDig;
               end else begin
                  acc = '0;
                  neg = 1'b0;
                  step = HEnd;
               end
            end
            HZero: begin
               if (c == "x" || c == "X") begin
                  step = HZeroX;
               end else if (c >= "0" && c <= "7") begin
                  base = BaseOct;
                  add_length_digit(64'(d));
                  step = HDig;
               end else begin
                  step = HEnd;
               end
            end
            HZeroX: begin
               if (d < 7'd16) begin
                  base = BaseHex;
                  add_length_digit(64'(d));
                  step = HDig;
               end else begin
                  step = HEnd;
               end
            end
            HDig: begin
               if (64'(d) < radix()) add_length_digit(64'(d));
               else step = HEnd;
            end
            default: ;
         endcase
      endfunction

      function void content_byte(logic [7:0] c);
         if (phase == PhStatus) status_char(c);
         else header_char(c);
         if (pos < PosMax) pos = pos + 5'd1;
      endfunction

      function void line_end();
         logic [31:0] m;
         logic [63:0] v;
         if (phase == PhStatus) begin
            if (step == SStDig || step == SDone) begin
               m = acc[31:0];
               if (neg) status = 16'(32'd0 - m);
               else status = (m > 32'd32767) ? 16'h7FFF : m[15:0];
               phase = PhHeaders;
            end else begin
               phase = PhBroken;
            end
         end else if (pos == 5'd0) begin
            phase = PhBody;
         end else if (step >= HWs && step <= HEnd) begin
            v = (step == HDig || step == HEnd) ? acc : 64'd0;
            if (ovf) v = LenMax;
            else if (neg) v = (64'd0 - v) & LenMax;
            len = v;
            seen = 1'b1;
         end
         clear_line();
      endfunction

      function parse_view_type parse_byte(logic cmd, logic [7:0] c);
         parse_view_type view;
         if (cmd) begin
            phase = PhBroken;
         end else if (phase == PhStatus || phase == PhHeaders) begin
            if (cr) begin
               if (c == ChLf) begin
                  line_end();
               end else begin
                  // lone CR counts as a content byte
                  cr = 1'b0;
                  content_byte(ChCr);
                  if (c == ChCr) cr = 1'b1;
                  else content_byte(c);
               end
            end else if (c == ChCr) begin
               cr = 1'b1;
            end else begin
               content_byte(c);
            end
         end
         view.phase = phase;
         view.status = status;
         view.body_len = len[31:0];
         view.has_length = seen;
         view.headers_pending = (phase == PhStatus || phase == PhHeaders);
         return view;
      endfunction

      function void note_byte(logic cmd, logic [7:0] c);
         expected_views.push_back(parse_byte(cmd, c));
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_outcome(logic [1:0] ph, logic [15:0] sc, logic [31:0] cl, logic hl,
                         logic hp);
         parse_view_type want;
         if (expected_views.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = expected_views.pop_front();
            if (ph !== want.phase)
               report_mismatch($sformatf("phase got %0d want %0d", ph, want.phase));
            if (sc !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         $signed(sc), $signed(want.status)));
            if (cl !== want.body_len)
               report_mismatch($sformatf("length got %0h want %0h",
                                         cl, want.body_len));
            if (hl !== want.has_length)
               report_mismatch($sformatf("has_length got %0b want %0b", hl, want.has_length));
            if (hp !== want.headers_pending)
               report_mismatch($sformatf("headers_pending got %0b want %0b",
                                         hp, want.headers_pending));
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_cmd = 1'b0;
   logic [7:0]        req_byte_value = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_phase;
   logic signed [15:0] rsp_status;
   logic [31:0]       rsp_length;
   logic              rsp_has_length;
   logic              rsp_headers_pending;

   logic              quiet = 1'b0;
   int                sent = 0;
   int                cycles = 0;
   logic [7:0]        line_bytes[$];
   parse_scoreboard   sb = new();

   http_response_header_parser u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_byte_value      (req_byte_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phase           (rsp_phase),
      .rsp_status          (rsp_status),
      .rsp_length          (rsp_length),
      .rsp_has_length      (rsp_has_length),
      .rsp_headers_pending (rsp_headers_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_outcome(rsp_phase, rsp_status, rsp_length, rsp_has_length,
                          rsp_headers_pending);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [7:0] b);
      logic calm;
      calm = (sent >= QuietFirst && sent < QuietLast);
      quiet <= calm;
      if (!calm) begin
         while ($urandom_range(99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(cmd, b);
      sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_item(1'b0, line_bytes[i]);
      line_bytes.delete();
   endtask

   // hold off until the block has returned every result
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // an LF right after a CR would end the line early, so swap it out
   function automatic void add_content(logic [7:0] b);
      if (b == ChLf && line_bytes.size() != 0 && line_bytes[$] == ChCr) b = "A";
      line_bytes.push_back(b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_content(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(3))
         0: return " ";
         1: return 8'h09;
         2: return ChCr;
         default: return 8'h0B;
      endcase
   endfunction

   function automatic void build_length_line();
      int n;
      add_text("Content-Length: ");
      // near miss on the prefix
      if ($urandom_range(9) == 0) line_bytes[$urandom_range(15)] = 8'($urandom_range(255));
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) add_content(space_char());
      case ($urandom_range(11))
         0: add_content("+");
         1: add_content("-");
         2: add_text("-+");
         default: ;
      endcase
      case ($urandom_range(9))
         0, 1, 2: begin
            n = ($urandom_range(4) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 9);
            add_content(8'("0" + $urandom_range(1, 9)));
            repeat (n - 1) add_content(8'("0" + $urandom_range(9)));
         end
         3, 4: begin
            n = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            add_content("0");
            add_content($urandom_range(1) ? "x" : "X");
            repeat (n) add_content(hex_char($urandom_range(15)));
         end
         5: begin
            n = ($urandom_range(4) == 0) ? $urandom_range(11, 16) : $urandom_range(0, 10);
            add_content("0");
            repeat (n) add_content(8'("0" + $urandom_range(7)));
         end
         6: begin
            case ($urandom_range(6))
               0: add_text("4294967295");
               1: add_text("4294967296");
               2: add_text("0xFFFFFFFF");
               3: add_text("0x100000000");
               4: add_text("037777777777");
               5: add_text("040000000000");
               default: add_text("0");
            endcase
         end
         7: begin
            add_text($urandom_range(1) ? "0x" : "0X");
            if ($urandom_range(1)) add_content("g");
         end
         8: if ($urandom_range(1)) add_content(8'("G" + $urandom_range(15)));
         default: begin
            add_text($urandom_range(1) ? "000" : "0x000");
            repeat ($urandom_range(1, 4)) add_content(hex_char($urandom_range(15)));
         end
      endcase
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) add_content(8'($urandom_range(255)));
      if ($urandom_range(7) == 0) begin
         add_content(8'h00);
         repeat ($urandom_range(0, 3)) add_content(8'("0" + $urandom_range(9)));
      end
   endfunction

   function automatic void build_noise_line();
      case ($urandom_range(3))
         0: add_text("Content-Length");
         1: add_text("Content-Length:");
         default: ;
      endcase
      repeat ($urandom_range(1, 30)) begin
         if ($urandom_range(9) == 0) add_content(ChCr);
         else add_content(8'($urandom_range(255)));
      end
   endfunction

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // status line: lone CR before the minor version, negative status that
      // saturates, then a NUL that cuts off the rest of the line
      add_text("HTTP/1.");
      line_bytes.push_back(ChCr);
      add_text("1-99999");
      line_bytes.push_back(8'h00);
      add_text("x");
      line_bytes.push_back(ChCr);
      line_bytes.push_back(ChLf);
      send_line();

      while (sent < ItemTarget) begin
         if ($urandom_range(9) < 7) build_length_line();
         else build_noise_line();
         line_bytes.push_back(ChCr);
         line_bytes.push_back(ChLf);
         send_line();
         if ((!paused && sent >= 1200) || $urandom_range(49) == 0) begin
            drain_pause();
            paused = 1'b1;
         end
      end

      // empty line into the body, ignored bytes, then end of stream twice
      send_item(1'b0, ChCr);
      send_item(1'b0, ChLf);
      repeat (3) send_item(1'b0, 8'($urandom_range(255)));
      send_item(1'b1, 8'($urandom_range(255)));
      repeat (2) send_item(1'b0, 8'($urandom_range(255)));
      send_item(1'b1, 8'($urandom_range(255)));

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_in_reg.sv
hw/rtl/hrp_core.sv
hw/rtl/http_response_header_parser.sv
bench/http_response_header_parser_tb.sv
